// ----- rtl/tile_residency_lru_cache_assert.svh -----
// Assertion macros used by the checker file of the tile residency cache.
`ifndef TILE_RESIDENCY_LRU_CACHE_ASSERT_SVH
`define TILE_RESIDENCY_LRU_CACHE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/trc_pkg.sv -----
// Types and constants of the tile residency cache.
`timescale 1ns / 1ps
package trc_pkg;

   typedef enum logic [1:0] {
      REQ_LOOKUP    = 2'd0,
      REQ_UPLOAD    = 2'd1,
      REQ_SCHED_ALL = 2'd2,
      REQ_CLEAR     = 2'd3
   } req_op_type;

   typedef struct packed {
      logic        occupied;
      logic [15:0] tile;
      logic [31:0] source;
      logic        in_video;
      logic        pending;
      logic [31:0] stamp;
   } slot_entry_type;

   localparam int ENTRY_W    = $bits(slot_entry_type);
   localparam int RSP_SLOT_W = 10;
   localparam int RSP_CNT_W  = 11;

endpackage

// ----- rtl/trc_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module trc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/tile_residency_lru_cache.sv -----
// Top level of the tile residency cache: slot table sequencer and statistics.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_type, req_tile_id, req_data_addr
//  rsp      out        rsp_valid/rsp_stall  hit, resident, slot, stats, counts
//  csr      in         csr_valid/csr_ready  csr_cache_enable
//
// Lookup, upload pass and schedule-all scan every slot through the table RAM,
// one slot a cycle, as set by the single read port. Clear sweeps the RAM,
// zeroing every slot. Disabled or rejected lookups and disabled upload
// passes answer without a scan. After reset a clearing pass over every slot
// runs before req is taken. A finished result waits in the rsp register;
// the next transaction may already be taken meanwhile, and the sequencer
// holds in DONE until rsp frees.
`timescale 1ns / 1ps
module tile_residency_lru_cache #(
   parameter int SLOTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [15:0] req_tile_id,
   input  logic [31:0]        req_data_addr,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic               rsp_resident,
   output logic [9:0]         rsp_slot_index,
   output logic               rsp_evicted,
   output logic [10:0]        rsp_uploads_done,
   output logic [31:0]        rsp_total_requests,
   output logic [31:0]        rsp_total_hits,
   output logic [31:0]        rsp_total_misses,
   output logic [31:0]        rsp_total_uploads,
   output logic [31:0]        rsp_total_evictions,
   output logic [10:0]        rsp_resident_count,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_cache_enable
);

   import trc_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLR, ST_IDLE, ST_SCAN, ST_TAIL, ST_WRITE, ST_DONE
   } state_type;

   state_type      state_ff;
   logic [IW-1:0]  cnt_ff;
   logic           rvalid_ff;
   logic [IW-1:0]  ridx_ff;
   req_op_type     op_ff;
   logic [15:0]    tid_ff;
   logic [31:0]    addr_ff;
   logic           enable_ff;
   logic           clr_rsp_ff;
   logic [31:0]    tick_ff;
   logic [31:0]    st_req_ff, st_hit_ff, st_miss_ff, st_upl_ff, st_evi_ff;
   logic [CW-1:0]  res_cnt_ff;
   logic [CW-1:0]  upl_cnt_ff;

   // search results of a lookup scan
   logic           found_ff;
   logic [IW-1:0]  found_idx_ff;
   slot_entry_type found_ent_ff;
   logic           free_ff;
   logic [IW-1:0]  free_idx_ff;
   logic           min_valid_ff;
   logic [IW-1:0]  min_idx_ff;
   logic [31:0]    min_stamp_ff;
   logic           min_inv_ff;

   // result held until rsp frees
   logic           r_hit_ff, r_res_ff, r_evi_ff;
   logic [9:0]     r_sidx_ff;

   logic           rsp_valid_ff;

   // RAM ports
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   slot_entry_type       wr_ent;
   logic [ENTRY_W-1:0]   rd_data;
   slot_entry_type       ent;

   // lookup write-back
   logic [31:0]    tick_in;
   logic [31:0]    src_in;
   logic [IW-1:0]  target;
   slot_entry_type new_ent;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign ent       = slot_entry_type'(rd_data);

   trc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_en  (state_ff == ST_SCAN),
      .rd_addr(cnt_ff),
      .rd_data(rd_data)
   );

   // entry written at the end of a lookup
   always_comb begin
      tick_in = tick_ff + 32'd1;
      src_in  = ((found_ent_ff.source == 32'd0) && (addr_ff != 32'd0)) ?
                addr_ff : found_ent_ff.source;
      if (found_ff) begin
         target           = found_idx_ff;
         new_ent          = found_ent_ff;
         new_ent.source   = src_in;
         new_ent.pending  = found_ent_ff.pending |
                            (!found_ent_ff.in_video && (src_in != 32'd0));
         new_ent.stamp    = tick_in;
      end else begin
         target           = free_ff ? free_idx_ff : min_idx_ff;
         new_ent.occupied = 1'b1;
         new_ent.tile     = tid_ff;
         new_ent.source   = addr_ff;
         new_ent.in_video = 1'b0;
         new_ent.pending  = 1'b1;
         new_ent.stamp    = tick_in;
      end
   end

   // RAM write: clearing sweep, lookup write-back, or scan read-modify-write
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ridx_ff;
      wr_ent  = ent;
      case (state_ff)
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_ent  = '0;
         end
         ST_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = target;
            wr_ent  = new_ent;
         end
         default: begin
            if (rvalid_ff) begin
               if ((op_ff == REQ_UPLOAD) && ent.pending && (ent.source != 32'd0)) begin
                  wr_en           = 1'b1;
                  wr_ent.in_video = 1'b1;
                  wr_ent.pending  = 1'b0;
               end else if ((op_ff == REQ_SCHED_ALL) && ent.occupied) begin
                  wr_en          = 1'b1;
                  wr_ent.pending = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         rvalid_ff    <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         enable_ff    <= 1'b1;
         tick_ff      <= '0;
         st_req_ff    <= '0;
         st_hit_ff    <= '0;
         st_miss_ff   <= '0;
         st_upl_ff    <= '0;
         st_evi_ff    <= '0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rvalid_ff <= (state_ff == ST_SCAN);
         ridx_ff   <= cnt_ff;

         if (csr_valid && csr_ready) begin
            enable_ff <= csr_cache_enable;
         end

         // in DONE the result load below owns rsp_valid_ff
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         // scan data from the table
         if (rvalid_ff) begin
            case (op_ff)
               REQ_LOOKUP: begin
                  if (ent.occupied && (ent.tile == tid_ff) && !found_ff) begin
                     found_ff     <= 1'b1;
                     found_idx_ff <= ridx_ff;
                     found_ent_ff <= ent;
                  end
                  if (!ent.occupied && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= ridx_ff;
                  end
                  // oldest stamp, lowest index on ties
                  if (ent.occupied && (!min_valid_ff || (ent.stamp < min_stamp_ff))) begin
                     min_valid_ff <= 1'b1;
                     min_idx_ff   <= ridx_ff;
                     min_stamp_ff <= ent.stamp;
                     min_inv_ff   <= ent.in_video;
                  end
               end
               REQ_UPLOAD: begin
                  if (ent.pending && (ent.source != 32'd0)) begin
                     upl_cnt_ff <= upl_cnt_ff + CW'(1);
                     st_upl_ff  <= st_upl_ff + 32'd1;
                     if (ent.occupied && !ent.in_video) begin
                        res_cnt_ff <= res_cnt_ff + CW'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         case (state_ff)
            ST_CLR: begin
               if (cnt_ff == LAST) begin
                  state_ff <= clr_rsp_ff ? ST_DONE : ST_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + IW'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  op_ff        <= req_op_type'(req_type);
                  tid_ff       <= req_tile_id;
                  addr_ff      <= req_data_addr;
                  cnt_ff       <= '0;
                  found_ff     <= 1'b0;
                  free_ff      <= 1'b0;
                  min_valid_ff <= 1'b0;
                  upl_cnt_ff   <= '0;
                  r_hit_ff     <= 1'b0;
                  r_res_ff     <= 1'b0;
                  r_evi_ff     <= 1'b0;
                  r_sidx_ff    <= '0;
                  case (req_op_type'(req_type))
                     REQ_LOOKUP: begin
                        if (enable_ff) begin
                           st_req_ff <= st_req_ff + 32'd1;
                           state_ff  <= req_tile_id[15] ? ST_DONE : ST_SCAN;
                        end else begin
                           state_ff <= ST_DONE;
                        end
                     end
                     REQ_UPLOAD: begin
                        state_ff <= enable_ff ? ST_SCAN : ST_DONE;
                     end
                     REQ_SCHED_ALL: begin
                        state_ff <= ST_SCAN;
                     end
                     REQ_CLEAR: begin
                        tick_ff    <= '0;
                        st_req_ff  <= '0;
                        st_hit_ff  <= '0;
                        st_miss_ff <= '0;
                        st_upl_ff  <= '0;
                        st_evi_ff  <= '0;
                        res_cnt_ff <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= ST_CLR;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (cnt_ff == LAST) begin
                  state_ff <= ST_TAIL;
               end else begin
                  cnt_ff <= cnt_ff + IW'(1);
               end
            end
            ST_TAIL: begin
               // last slot's data is taken in this cycle
               state_ff <= (op_ff == REQ_LOOKUP) ? ST_WRITE : ST_DONE;
            end
            ST_WRITE: begin
               tick_ff <= tick_in;
               if (found_ff) begin
                  st_hit_ff <= st_hit_ff + 32'd1;
                  r_hit_ff  <= 1'b1;
                  r_res_ff  <= found_ent_ff.in_video;
                  r_sidx_ff <= found_ent_ff.in_video ? RSP_SLOT_W'(found_idx_ff) : 10'd0;
               end else begin
                  st_miss_ff <= st_miss_ff + 32'd1;
                  if (!free_ff) begin
                     st_evi_ff <= st_evi_ff + 32'd1;
                     r_evi_ff  <= 1'b1;
                     if (min_inv_ff) begin
                        res_cnt_ff <= res_cnt_ff - CW'(1);
                     end
                  end
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_hit             <= r_hit_ff;
                  rsp_resident        <= r_res_ff;
                  rsp_slot_index      <= r_sidx_ff;
                  rsp_evicted         <= r_evi_ff;
                  rsp_uploads_done    <= RSP_CNT_W'(upl_cnt_ff);
                  rsp_total_requests  <= st_req_ff;
                  rsp_total_hits      <= st_hit_ff;
                  rsp_total_misses    <= st_miss_ff;
                  rsp_total_uploads   <= st_upl_ff;
                  rsp_total_evictions <= st_evi_ff;
                  rsp_resident_count  <= RSP_CNT_W'(res_cnt_ff);
                  clr_rsp_ff          <= 1'b0;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/trc_checker.sv -----
// Port-level checks of the tile residency cache, bound to the top level.
`timescale 1ns / 1ps
`include "tile_residency_lru_cache_assert.svh"
module trc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic        rsp_resident,
   input logic [9:0]  rsp_slot_index,
   input logic        rsp_evicted,
   input logic [10:0] rsp_uploads_done
);

   `TRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")
   `TRC_ASSERT_NOW(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted, "hit with eviction")
   `TRC_ASSERT_NOW(a_slot_zero, clock, reset, rsp_valid && !rsp_resident, rsp_slot_index == 10'd0, "slot index without residency")
   `TRC_ASSERT_NOW(a_upload_only, clock, reset, rsp_valid && (rsp_uploads_done != 11'd0), !rsp_hit && !rsp_resident && !rsp_evicted, "uploads reported on lookup")
   `TRC_ASSERT_NOW(a_clear_pass, clock, reset, $past(reset), req_stall, "request taken during clearing pass")

endmodule

bind tile_residency_lru_cache trc_checker u_trc_checker (.*);

// ----- verif/tb_tile_residency_lru_cache.sv -----
// Self-checking testbench of the tile residency cache: queued stimulus, predicted responses.
`timescale 1ns / 1ps
module tb_tile_residency_lru_cache;
   import trc_pkg::*;

   localparam int NSLOT = 1024;
   // settle time after the queues empty, with generous slack
   localparam int SETTLE_CYC = 3 * NSLOT;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] tile;
      logic [31:0] addr;
   } tile_req_t;

   typedef struct packed {
      logic        hit;
      logic        resident;
      logic [9:0]  slot;
      logic        evicted;
      logic [10:0] uploads;
      logic [31:0] n_req;
      logic [31:0] n_hit;
      logic [31:0] n_miss;
      logic [31:0] n_upl;
      logic [31:0] n_evi;
      logic [10:0] n_res;
   } tile_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic signed [15:0] req_tile_id = '0;
   logic [31:0] req_data_addr = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit, rsp_resident, rsp_evicted;
   logic [9:0] rsp_slot_index;
   logic [10:0] rsp_uploads_done, rsp_resident_count;
   logic [31:0] rsp_total_requests, rsp_total_hits, rsp_total_misses;
   logic [31:0] rsp_total_uploads, rsp_total_evictions;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_cache_enable = 1'b1;

   tile_residency_lru_cache dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_tile_id(req_tile_id), .req_data_addr(req_data_addr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_resident(rsp_resident), .rsp_slot_index(rsp_slot_index),
      .rsp_evicted(rsp_evicted), .rsp_uploads_done(rsp_uploads_done),
      .rsp_total_requests(rsp_total_requests), .rsp_total_hits(rsp_total_hits),
      .rsp_total_misses(rsp_total_misses), .rsp_total_uploads(rsp_total_uploads),
      .rsp_total_evictions(rsp_total_evictions),
      .rsp_resident_count(rsp_resident_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_cache_enable(csr_cache_enable)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Shadow of the slot table, used to predict every response
   // ---------------------------------------------------------------
   logic        sh_occ [NSLOT];
   logic [15:0] sh_tile [NSLOT];
   logic [31:0] sh_src [NSLOT];
   logic        sh_vid [NSLOT];
   logic        sh_pend [NSLOT];
   logic [31:0] sh_stamp [NSLOT];
   logic [31:0] sh_tick;
   logic [31:0] st_req, st_hit, st_miss, st_upl, st_evi;
   logic        sh_enable;

   tile_req_t pending_reqs[$];
   tile_rsp_t expected_rsps[$];
   int        rsp_stall_pct = 0;
   int        req_idle_pct = 0;
   bit        hold_rsp = 1'b0;
   int        fail_count = 0;

   function automatic void wipe_table();
      for (int i = 0; i < NSLOT; i++) begin
         sh_occ[i] = 0; sh_tile[i] = 0; sh_src[i] = 0;
         sh_vid[i] = 0; sh_pend[i] = 0; sh_stamp[i] = 0;
      end
      sh_tick = 0;
      st_req = 0; st_hit = 0; st_miss = 0; st_upl = 0; st_evi = 0;
   endfunction

   // Apply one transaction to the shadow table and return the response it yields
   function automatic tile_rsp_t predict_residency(tile_req_t r);
      tile_rsp_t o;
      int found, s;
      bit got_free;
      int cnt;
      o = '0;
      found = -1;
      case (req_op_type'(r.op))
         REQ_LOOKUP: begin
            if (sh_enable) begin
               st_req++;
               if (!r.tile[15]) begin
                  for (int i = 0; i < NSLOT; i++)
                     if (found < 0 && sh_occ[i] && sh_tile[i] == r.tile) found = i;
                  if (found >= 0) begin
                     st_hit++;
                     o.hit = 1;
                     if (sh_src[found] == 0 && r.addr != 0) sh_src[found] = r.addr;
                     if (!sh_vid[found] && sh_src[found] != 0) sh_pend[found] = 1;
                     sh_tick++;
                     sh_stamp[found] = sh_tick;
                     if (sh_vid[found]) begin
                        o.resident = 1;
                        o.slot = found[9:0];
                     end
                  end else begin
                     st_miss++;
                     s = 0;
                     got_free = 0;
                     for (int i = 0; i < NSLOT && !got_free; i++) begin
                        if (!sh_occ[i]) begin
                           s = i;
                           got_free = 1;
                        end else if (sh_stamp[i] < sh_stamp[s]) s = i;
                     end
                     if (!got_free) begin
                        st_evi++;
                        o.evicted = 1;
                     end
                     sh_occ[s] = 1; sh_tile[s] = r.tile; sh_src[s] = r.addr;
                     sh_vid[s] = 0; sh_pend[s] = 1;
                     sh_tick++;
                     sh_stamp[s] = sh_tick;
                  end
               end
            end
         end
         REQ_UPLOAD: begin
            if (sh_enable)
               for (int i = 0; i < NSLOT; i++)
                  if (sh_pend[i] && sh_src[i] != 0) begin
                     st_upl++;
                     sh_vid[i] = 1;
                     sh_pend[i] = 0;
                     o.uploads++;
                  end
         end
         REQ_SCHED_ALL: begin
            for (int i = 0; i < NSLOT; i++)
               if (sh_occ[i]) sh_pend[i] = 1;
         end
         default: wipe_table();
      endcase
      cnt = 0;
      for (int i = 0; i < NSLOT; i++)
         if (sh_occ[i] && sh_vid[i]) cnt++;
      o.n_req = st_req; o.n_hit = st_hit; o.n_miss = st_miss;
      o.n_upl = st_upl; o.n_evi = st_evi; o.n_res = cnt[10:0];
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Driver: next pending transaction, with random idle cycles
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      tile_req_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // current transaction (if any) was taken at this edge
         if (req_valid) void'(pending_reqs.pop_front());
         if (pending_reqs.size() > (req_valid ? 1 : 0) - (req_valid ? 1 : 0) &&
             pending_reqs.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            nxt = pending_reqs[0];
            req_valid     <= 1'b1;
            req_type      <= nxt.op;
            req_tile_id   <= nxt.tile;
            req_data_addr <= nxt.addr;
            expected_rsps.push_back(predict_residency(nxt));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall, random or held off for a long stretch
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
   end

   // ---------------------------------------------------------------
   // Monitor: compare every accepted response with the oldest prediction
   // ---------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      tile_rsp_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response with none outstanding");
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            check_field("hit", e.hit, rsp_hit);
            check_field("resident", e.resident, rsp_resident);
            check_field("slot_index", e.slot, rsp_slot_index);
            check_field("evicted", e.evicted, rsp_evicted);
            check_field("uploads_done", e.uploads, rsp_uploads_done);
            check_field("total_requests", e.n_req, rsp_total_requests);
            check_field("total_hits", e.n_hit, rsp_total_hits);
            check_field("total_misses", e.n_miss, rsp_total_misses);
            check_field("total_uploads", e.n_upl, rsp_total_uploads);
            check_field("total_evictions", e.n_evi, rsp_total_evictions);
            check_field("resident_count", e.n_res, rsp_resident_count);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic tile_req_t mk(req_op_type op, logic [15:0] t, logic [31:0] a);
      tile_req_t r;
      r.op = op; r.tile = t; r.addr = a;
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // register write, only while idle
   task automatic write_enable(logic en);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_cache_enable <= en;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sh_enable = en;
   endtask

   // random tile id, mostly from a small pool so hits happen
   function automatic logic [15:0] pick_tile();
      int k;
      k = $urandom_range(99);
      if (k < 75) return 16'($urandom_range(40));
      if (k < 90) return 16'($urandom_range(16'h7fff));
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_addr();
      int k;
      k = $urandom_range(9);
      if (k < 3) return 32'h0;
      if (k == 3) return 32'hffff_ffff;
      return $urandom;
   endfunction

   task automatic random_batch(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 70)      pending_reqs.push_back(mk(REQ_LOOKUP, pick_tile(), pick_addr()));
         else if (k < 88) pending_reqs.push_back(mk(REQ_UPLOAD, 16'($urandom), $urandom));
         else if (k < 97) pending_reqs.push_back(mk(REQ_SCHED_ALL, 16'($urandom), $urandom));
         else             pending_reqs.push_back(mk(REQ_CLEAR, 16'($urandom), $urandom));
      end
   endtask

   initial begin
      sh_enable = 1'b1;
      wipe_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: miss with and without data, hits, upload, extremes, special cases
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0000, 32'h0));          // miss, no data
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h7fff, 32'hffff_ffff));
      pending_reqs.push_back(mk(REQ_UPLOAD, 16'h0, 32'h0));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0000, 32'h1234_5678));  // hit fills source
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h7fff, 32'h0));          // resident hit
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h8000, 32'h1));          // negative id
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'hffff, 32'hffff_ffff));
      pending_reqs.push_back(mk(REQ_UPLOAD, 16'hffff, 32'hffff_ffff));
      pending_reqs.push_back(mk(REQ_SCHED_ALL, 16'h0, 32'h0));          // re-schedule resident
      pending_reqs.push_back(mk(REQ_UPLOAD, 16'h0, 32'h0));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0000, 32'h0));
      pending_reqs.push_back(mk(REQ_CLEAR, 16'hffff, 32'hffff_ffff));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0000, 32'h0));
      drain();

      // disabled: lookups and uploads void, schedule-all and clear still act
      write_enable(1'b0);
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0005, 32'h55));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0000, 32'h55));
      pending_reqs.push_back(mk(REQ_SCHED_ALL, 16'h0, 32'h0));
      pending_reqs.push_back(mk(REQ_UPLOAD, 16'h0, 32'h0));
      pending_reqs.push_back(mk(REQ_CLEAR, 16'h0, 32'h0));
      drain();
      write_enable(1'b1);

      // fill a run of slots, then misses and a hit on the filled run
      for (int i = 0; i < 160; i++)
         pending_reqs.push_back(mk(REQ_LOOKUP, 16'(100 + i), (i % 3 == 0) ? 32'h0 : $urandom));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0aaa, 32'h1));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0101, 32'h2));
      pending_reqs.push_back(mk(REQ_LOOKUP, 16'h0bbb, 32'h3));
      pending_reqs.push_back(mk(REQ_UPLOAD, 16'h0, 32'h0));
      drain();

      // random phases: no idling, sender idle, receiver stalling (first with the cache disabled), both
      random_batch(70);
      drain();
      req_idle_pct = 80;
      random_batch(60);
      drain();
      write_enable(1'b0);
      req_idle_pct = 0;
      rsp_stall_pct = 80;
      random_batch(38);
      drain();
      write_enable(1'b1);
      random_batch(50);
      drain();
      req_idle_pct = 25;
      rsp_stall_pct = 25;
      random_batch(50);
      // long hold-off on the receiver while the sender keeps offering
      hold_rsp = 1'b1;
      repeat (5000) @(posedge clock);
      hold_rsp = 1'b0;
      drain();

      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
